>>> sv/dns_resource_record_walker_defines.svh
// Assertion helpers for the record walker.
`ifndef DNS_RESOURCE_RECORD_WALKER_DEFINES_SVH
`define DNS_RESOURCE_RECORD_WALKER_DEFINES_SVH
`ifndef SYNTHESIS
`define DRW_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define DRW_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define DRW_ASSERT_IMP(label, clk, rst_n, a, c)
`define DRW_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> sv/drrw_pkg.sv
`default_nettype none
package drrw_pkg;
    localparam int MAX_MESSAGE_BYTES = 65535;
    localparam logic [15:0] OPT_RECORD_TYPE = 16'd41;
    localparam logic [16:0] HEADER_LAST = 17'd11;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    localparam logic [3:0] PH_HEADER    = 4'd0;
    localparam logic [3:0] PH_NAME_LEN  = 4'd1;
    localparam logic [3:0] PH_NAME_SKIP = 4'd2;
    localparam logic [3:0] PH_NAME_PTR  = 4'd3;
    localparam logic [3:0] PH_QFIXED    = 4'd4;
    localparam logic [3:0] PH_RFIXED    = 4'd5;
    localparam logic [3:0] PH_RDATA     = 4'd6;
    localparam logic [3:0] PH_DONE      = 4'd7;
    localparam logic [3:0] PH_ERROR     = 4'd8;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_HDR_BAD = 2'd1;
    localparam logic [1:0] ST_REC_BAD = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [15:0] owner_offset;
        logic [15:0] record_type;
        logic [15:0] record_class;
        logic [31:0] time_to_live;
        logic [15:0] rdata_length;
        logic [15:0] rdata_offset;
        logic [1:0]  section;
        logic [1:0]  status;
        logic        opt_found;
        logic        dnssec_ok;
        logic [15:0] record_count;
    } result_t;
endpackage
`default_nettype wire

>>> sv/drrw_front.sv
`default_nettype none
// Byte parser; emits up to two results per byte into the queue.
module drrw_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire logic [7:0]        data_byte,
    input  wire logic              is_last,
    output drrw_pkg::result_t      res_a,
    output logic                   res_a_vld,
    output drrw_pkg::result_t      res_b,
    output logic                   res_b_vld
);
    import drrw_pkg::*;

    logic [16:0] pos_reg, pos_next;
    logic [3:0]  ph_reg, ph_next;
    logic [7:0]  skip_reg, skip_next;
    logic [15:0] ql_reg, ql_next, an_reg, an_next, ns_reg, ns_next;
    logic [17:0] tot_reg, tot_next, idx_reg, idx_next;
    logic [79:0] sh_reg, sh_next;
    logic [15:0] own_reg, own_next, rdl_reg, rdl_next;
    logic        opt_reg, opt_next, do_reg, do_next;
    logic [1:0]  err_reg, err_next;
    logic [17:0] an_ns;

    always_comb begin
        logic        emit;
        logic [79:0] sh;
        logic [1:0]  st;
        pos_next = pos_reg; ph_next = ph_reg; skip_next = skip_reg;
        ql_next = ql_reg; an_next = an_reg; ns_next = ns_reg;
        tot_next = tot_reg; idx_next = idx_reg; sh_next = sh_reg;
        own_next = own_reg; rdl_next = rdl_reg; opt_next = opt_reg;
        do_next = do_reg; err_next = err_reg;
        emit = 1'b0;
        st = ST_OK;
        sh = {sh_reg[71:0], data_byte};
        an_ns = {2'b0, an_reg} + {2'b0, ns_reg};
        res_a = '0;
        res_b = '0;
        res_a_vld = 1'b0;
        res_b_vld = 1'b0;
        if (pos_reg < 17'(MAX_MESSAGE_BYTES)) begin
            pos_next = pos_reg + 17'd1;
            unique case (ph_reg)
                PH_HEADER: begin
                    sh_next = sh;
                    if (pos_reg == HEADER_LAST) begin
                        ql_next = sh[63:48];
                        an_next = sh[47:32];
                        ns_next = sh[31:16];
                        tot_next = {2'b0, sh[47:32]} + {2'b0, sh[31:16]}
                                   + {2'b0, sh[15:0]};
                        if (sh[63:48] != 16'd0) ph_next = PH_NAME_LEN;
                        else if (tot_next != 18'd0) begin
                            ph_next = PH_NAME_LEN;
                            own_next = pos_next[15:0];
                        end else ph_next = PH_DONE;
                    end
                end
                PH_NAME_LEN: begin
                    if (data_byte == 8'd0 || data_byte[7:6] == 2'b11) begin
                        if (data_byte != 8'd0) ph_next = PH_NAME_PTR;
                        else if (ql_reg != 16'd0) begin
                            ph_next = PH_QFIXED; skip_next = 8'd4;
                        end else begin
                            ph_next = PH_RFIXED; skip_next = 8'd10; sh_next = '0;
                        end
                    end else if (data_byte > 8'd63) begin
                        err_next = (ql_reg != 16'd0) ? ST_HDR_BAD : ST_REC_BAD;
                        ph_next = PH_ERROR;
                    end else begin
                        skip_next = data_byte; ph_next = PH_NAME_SKIP;
                    end
                end
                PH_NAME_SKIP: begin
                    skip_next = skip_reg - 8'd1;
                    if (skip_next == 8'd0) ph_next = PH_NAME_LEN;
                end
                PH_NAME_PTR: begin
                    if (ql_reg != 16'd0) begin
                        ph_next = PH_QFIXED; skip_next = 8'd4;
                    end else begin
                        ph_next = PH_RFIXED; skip_next = 8'd10; sh_next = '0;
                    end
                end
                PH_QFIXED: begin
                    skip_next = skip_reg - 8'd1;
                    if (skip_next == 8'd0) begin
                        ql_next = ql_reg - 16'd1;
                        if (ql_next != 16'd0) ph_next = PH_NAME_LEN;
                        else if (idx_reg < tot_reg) begin
                            ph_next = PH_NAME_LEN; own_next = pos_next[15:0];
                        end else ph_next = PH_DONE;
                    end
                end
                PH_RFIXED: begin
                    sh_next = sh;
                    skip_next = skip_reg - 8'd1;
                    if (skip_next == 8'd0) begin
                        rdl_next = sh[15:0];
                        if (sh[15:0] == 16'd0) emit = 1'b1;
                        else ph_next = PH_RDATA;
                    end
                end
                PH_RDATA: begin
                    rdl_next = rdl_reg - 16'd1;
                    if (rdl_next == 16'd0) emit = 1'b1;
                end
                default: ;
            endcase
            if (emit) begin
                res_a_vld = 1'b1;
                res_a.owner_offset = own_reg;
                res_a.record_type = sh_next[79:64];
                res_a.record_class = sh_next[63:48];
                res_a.time_to_live = sh_next[47:16];
                res_a.rdata_length = sh_next[15:0];
                res_a.rdata_offset = pos_next[15:0] - sh_next[15:0];
                if (idx_reg < {2'b0, an_reg}) res_a.section = 2'd0;
                else if (idx_reg < an_ns) res_a.section = 2'd1;
                else res_a.section = 2'd2;
                if (sh_next[79:64] == OPT_RECORD_TYPE && !opt_reg) begin
                    opt_next = 1'b1; do_next = sh_next[31];
                end
                idx_next = idx_reg + 18'd1;
                if (idx_next < tot_reg) begin
                    ph_next = PH_NAME_LEN; own_next = pos_next[15:0];
                end else ph_next = PH_DONE;
            end
        end
        if (is_last) begin
            if (ph_next == PH_DONE) st = ST_OK;
            else if (ph_next == PH_ERROR) st = err_next;
            else if (ph_next == PH_HEADER || ph_next == PH_QFIXED) st = ST_HDR_BAD;
            else if ((ph_next == PH_NAME_LEN || ph_next == PH_NAME_SKIP ||
                      ph_next == PH_NAME_PTR) && ql_next != 16'd0) st = ST_HDR_BAD;
            else st = ST_REC_BAD;
            res_b_vld = 1'b1;
            res_b.kind = 1'b1;
            res_b.status = st;
            res_b.opt_found = opt_next;
            res_b.dnssec_ok = do_next;
            res_b.record_count = idx_next[15:0];
            pos_next = '0; ph_next = PH_HEADER; skip_next = '0; ql_next = '0;
            an_next = '0; ns_next = '0; tot_next = '0; idx_next = '0;
            sh_next = '0; own_next = '0; rdl_next = '0; opt_next = 1'b0;
            do_next = 1'b0; err_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg <= '0; ph_reg <= PH_HEADER; skip_reg <= '0; ql_reg <= '0;
            an_reg <= '0; ns_reg <= '0; tot_reg <= '0; idx_reg <= '0;
            sh_reg <= '0; own_reg <= '0; rdl_reg <= '0; opt_reg <= 1'b0;
            do_reg <= 1'b0; err_reg <= '0;
        end else if (take) begin
            pos_reg <= pos_next; ph_reg <= ph_next; skip_reg <= skip_next;
            ql_reg <= ql_next; an_reg <= an_next; ns_reg <= ns_next;
            tot_reg <= tot_next; idx_reg <= idx_next; sh_reg <= sh_next;
            own_reg <= own_next; rdl_reg <= rdl_next; opt_reg <= opt_next;
            do_reg <= do_next; err_reg <= err_next;
        end
    end
endmodule
`default_nettype wire

>>> sv/drrw_queue.sv
`default_nettype none
`include "dns_resource_record_walker_defines.svh"
// Result queue; takes up to two entries per transfer, pops one.
module drrw_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_a,
    input  drrw_pkg::result_t      din_a,
    input  wire logic              wr_b,
    input  drrw_pkg::result_t      din_b,
    output logic                   full,
    output logic                   empty,
    input  wire logic              pop,
    output drrw_pkg::result_t      dout
);
    import drrw_pkg::*;

    result_t mem [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;
    logic           do_pop;
    logic [QAW:0]   n_wr;

    assign empty = (cnt_reg == '0);
    // two slots must be free since one byte can yield two results
    assign full = (cnt_reg > (QAW+1)'(QDEPTH - 2));
    assign do_pop = pop && !empty;
    assign n_wr = (QAW+1)'(wr_a) + (QAW+1)'(wr_b);
    assign dout = mem[rp_reg];

    always_ff @(posedge clk) begin
        if (wr_a) mem[wp_reg] <= din_a;
        if (wr_b) mem[wr_a ? wp_reg + QAW'(1) : wp_reg] <= din_b;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            wp_reg <= wp_reg + n_wr[QAW-1:0];
            if (do_pop) rp_reg <= rp_reg + QAW'(1);
            cnt_reg <= cnt_reg + n_wr - (QAW+1)'(do_pop);
        end
    end

    `DRW_ASSERT_IMP(a_no_overflow, clk, rst_n, 1'b1, cnt_reg <= (QAW+1)'(QDEPTH))
    `DRW_ASSERT_IMP(a_no_write_full, clk, rst_n, full, !wr_a && !wr_b)
    `DRW_ASSERT_NXT(a_cnt_step, clk, rst_n, !wr_a && !wr_b && do_pop,
        cnt_reg == $past(cnt_reg) - 1'b1)
endmodule
`default_nettype wire

>>> sv/dns_resource_record_walker.sv
`default_nettype none
// DNS resource record walker.
// Input channel: data_byte/is_last, transferred when push && !full. One
// message byte per transfer, is_last on its final byte.
// Output channel: while empty is low the oldest result is on the ports;
// pop && !empty transfers it. kind 0 is a record, kind 1 the summary
// that follows the last byte.
// Throughput: one byte per cycle while full is low. The parser updates
// all its state in the cycle of the transfer; results written then are
// visible in the cycle after. A four-entry queue sits between the parser
// and the output; full rises when fewer than two slots are free, since one
// byte can cause a record and a summary.
// A stalled receiver fills the queue and then holds off the sender.
// Reset empties the queue and returns the parser to the header of a new
// message; after is_last the parser also starts over.
module dns_resource_record_walker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        is_last,
    output logic             empty,
    input  wire logic        pop,
    output logic             kind,
    output logic [15:0]      owner_offset,
    output logic [15:0]      record_type,
    output logic [15:0]      record_class,
    output logic [31:0]      time_to_live,
    output logic [15:0]      rdata_length,
    output logic [15:0]      rdata_offset,
    output logic [1:0]       section,
    output logic [1:0]       status,
    output logic             opt_found,
    output logic             dnssec_ok,
    output logic [15:0]      record_count
);
    import drrw_pkg::*;

    result_t res_a, res_b, dout;
    logic    va, vb, take;

    assign take = push && !full;

    drrw_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .data_byte(data_byte),
        .is_last(is_last), .res_a(res_a), .res_a_vld(va),
        .res_b(res_b), .res_b_vld(vb)
    );

    drrw_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_a(take && va), .din_a(res_a),
        .wr_b(take && vb), .din_b(res_b), .full(full), .empty(empty),
        .pop(pop), .dout(dout)
    );

    assign kind = dout.kind;
    assign owner_offset = dout.owner_offset;
    assign record_type = dout.record_type;
    assign record_class = dout.record_class;
    assign time_to_live = dout.time_to_live;
    assign rdata_length = dout.rdata_length;
    assign rdata_offset = dout.rdata_offset;
    assign section = dout.section;
    assign status = dout.status;
    assign opt_found = dout.opt_found;
    assign dnssec_ok = dout.dnssec_ok;
    assign record_count = dout.record_count;
endmodule
`default_nettype wire
